// ----- rtl/gsd_pkg.sv -----
// shared constants and register index codes for the stick deadzone block
package gsd_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 15;

   // deadzone register is Q0.15
   localparam int DZ_FRAC_BITS = 15;
   localparam logic [CSR_DATA_BITS-1:0] DZ_RESET = 15'd4915;

   // register index codes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEADZONE    = 2'd0,
      CSR_PAD_PRESENT = 2'd1
   } csr_index_type;

endpackage

// ----- rtl/gsd_div.sv -----
// pipelined restoring divider, one quotient bit per register stage
module gsd_div #(
   parameter int DW = 16,
   parameter int QB = 15
) (
   input  logic          clock,
   input  logic [DW-1:0] in_hi,
   input  logic [QB-1:0] in_lo,
   input  logic [DW-1:0] in_den,
   output logic [QB-1:0] out_quo
);

   logic [DW-1:0] rem_ff [QB];
   logic [QB-1:0] lo_ff  [QB];
   logic [DW-1:0] den_ff [QB];
   logic [QB-1:0] quo_ff [QB];

   logic [DW-1:0] rem_src [QB];
   logic [QB-1:0] lo_src  [QB];
   logic [DW-1:0] den_src [QB];
   logic [QB-1:0] quo_src [QB];

   logic [DW-1:0] rem_in [QB];
   logic [QB-1:0] lo_in  [QB];
   logic [QB-1:0] quo_in [QB];

   logic [DW:0] trial [QB];
   logic        ge    [QB];

   // each stage shifts in one numerator bit and tries one subtract
   always_comb begin
      rem_src[0] = in_hi;
      lo_src[0]  = in_lo;
      den_src[0] = in_den;
      quo_src[0] = '0;
      for (int i = 1; i < QB; i++) begin
         rem_src[i] = rem_ff[i-1];
         lo_src[i]  = lo_ff[i-1];
         den_src[i] = den_ff[i-1];
         quo_src[i] = quo_ff[i-1];
      end
      for (int i = 0; i < QB; i++) begin
         trial[i]  = {rem_src[i], lo_src[i][QB-1]};
         ge[i]     = trial[i] >= {1'b0, den_src[i]};
         rem_in[i] = ge[i] ? DW'(trial[i] - {1'b0, den_src[i]}) : trial[i][DW-1:0];
         lo_in[i]  = {lo_src[i][QB-2:0], 1'b0};
         quo_in[i] = {quo_src[i][QB-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QB; i++) begin
         rem_ff[i] <= rem_in[i];
         lo_ff[i]  <= lo_in[i];
         den_ff[i] <= den_src[i];
         quo_ff[i] <= quo_in[i];
      end
   end

   assign out_quo = quo_ff[QB-1];

endmodule

// ----- rtl/gsd_isqrt.sv -----
// pipelined integer square root, one root bit per register stage
module gsd_isqrt #(
   parameter int F = 15
) (
   input  logic           clock,
   input  logic [2*F+1:0] in_num,
   output logic [F:0]     out_root
);

   localparam int NW = 2 * F + 2;
   localparam int RW = F + 3;
   localparam int ST = F + 1;

   logic [RW-1:0] rem_ff  [ST];
   logic [F:0]    root_ff [ST];
   logic [NW-1:0] num_ff  [ST];

   logic [RW-1:0] rem_src  [ST];
   logic [F:0]    root_src [ST];
   logic [NW-1:0] num_src  [ST];

   logic [RW-1:0] rem_in  [ST];
   logic [F:0]    root_in [ST];
   logic [NW-1:0] num_in  [ST];

   logic [RW+1:0] trial [ST];
   logic [RW+1:0] test  [ST];
   logic          ge    [ST];

   // bring down two bits, compare against 4*root+1
   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      num_src[0]  = in_num;
      for (int i = 1; i < ST; i++) begin
         rem_src[i]  = rem_ff[i-1];
         root_src[i] = root_ff[i-1];
         num_src[i]  = num_ff[i-1];
      end
      for (int i = 0; i < ST; i++) begin
         trial[i]   = {rem_src[i], num_src[i][NW-1:NW-2]};
         test[i]    = (RW+2)'({root_src[i], 2'b01});
         ge[i]      = trial[i] >= test[i];
         rem_in[i]  = ge[i] ? RW'(trial[i] - test[i]) : trial[i][RW-1:0];
         root_in[i] = {root_src[i][F-1:0], ge[i]};
         num_in[i]  = {num_src[i][NW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ST; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         num_ff[i]  <= num_in[i];
      end
   end

   assign out_root = root_ff[ST-1];

endmodule

// ----- rtl/gamepad_stick_deadzone.sv -----
// stick deadzone top level: radial and axial conditioning pipeline with output queue
//
// One stick sample (req_stick_x, req_stick_y) enters per transfer on the req_
// channel; one result (radial pair, axial pair, in_deadzone flag) leaves per
// transfer on the rsp_ channel, in order. The csr_ port writes the deadzone
// (index 0) and pad_present (index 1) registers; write them only while idle.
// Throughput: one sample per cycle while req_stall is low. The path from the
// input transfer to rsp_valid runs through the square root stages
// (one root bit each), the scale divider and the component dividers (one
// quotient bit each), plus input, squaring, multiply, queue and output
// register stages.
// The pipeline never stops; results land in an output queue sized to cover
// every sample in flight. req_stall rises only when the queue plus pipeline
// hold as many samples as the queue can take, so a stalled receiver backs up
// into req_stall after the queue fills and nothing is dropped.
// Reset (synchronous, active high) empties the pipeline and queue and loads
// deadzone = 4915 and pad_present = 1.
module gamepad_stick_deadzone #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_stick_x,
   input  logic signed [SAMPLE_BITS-1:0]        req_stick_y,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_radial_x,
   output logic signed [SAMPLE_BITS-1:0]        rsp_radial_y,
   output logic signed [SAMPLE_BITS-1:0]        rsp_axial_x,
   output logic signed [SAMPLE_BITS-1:0]        rsp_axial_y,
   output logic                                 rsp_in_deadzone,
   // register writes
   input  logic                                 csr_write,
   input  logic [gsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gsd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int W      = SAMPLE_BITS;
   localparam int F      = W - 1;
   localparam int BL_LEN = 3 * F + 5;
   localparam int KM_LEN = 2 * F + 2;
   localparam int AX_LEN = 2 * F + 5;
   localparam int V_LEN  = 3 * F + 7;
   localparam int FIFO_DEPTH = 1 << $clog2(3 * F + 10);
   localparam int AW     = $clog2(FIFO_DEPTH);
   localparam logic [F:0]   ONE     = {1'b1, {F{1'b0}}};
   localparam logic [AW:0]  FULL    = (AW+1)'(FIFO_DEPTH);

   typedef struct packed {
      logic [F:0]   ax;
      logic [F:0]   ay;
      logic         negx;
      logic         negy;
      logic         ltx;
      logic         lty;
      logic         onex;
      logic         oney;
      logic [F-1:0] dz;
      logic         pad;
   } bstage_type;

   typedef struct packed {
      logic [F:0] m;
      logic       in_dz;
      logic       rz;
      logic       s_one;
   } mstage_type;

   typedef struct packed {
      logic [W-1:0] ax;
      logic [W-1:0] ay;
   } axial_type;

   typedef struct packed {
      logic [W-1:0] rx;
      logic [W-1:0] ry;
      logic [W-1:0] ax;
      logic [W-1:0] ay;
      logic         indz;
   } result_type;

   // sign and saturate a magnitude of at most ONE
   function automatic logic [W-1:0] pack_mag(input logic neg, input logic [F:0] mag);
      logic [W-1:0] r;
      if (neg) begin
         r = W'(~mag + 1'b1);
      end else begin
         r = mag[F] ? {1'b0, {F{1'b1}}} : mag;
      end
      return r;
   endfunction

   // configuration registers
   logic [gsd_pkg::CSR_DATA_BITS-1:0] deadzone_ff;
   logic                              pad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= gsd_pkg::DZ_RESET;
         pad_ff      <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            gsd_pkg::CSR_DEADZONE:    deadzone_ff <= csr_wdata;
            gsd_pkg::CSR_PAD_PRESENT: pad_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input transfer
   logic req_fire;
   assign req_fire = req_valid && !req_stall;

   // valid line, one bit per stage
   logic [V_LEN-1:0] v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[V_LEN-2:0], req_fire};
      end
   end

   // stage a: capture sample and converted deadzone
   logic [W-1:0]           x_a_ff, y_a_ff;
   logic [F-1:0]           dz_a_ff;
   logic                   pad_a_ff;
   logic [F+gsd_pkg::DZ_FRAC_BITS-1:0] dz_wide;

   assign dz_wide = {deadzone_ff, {F{1'b0}}} >> gsd_pkg::DZ_FRAC_BITS;

   always_ff @(posedge clock) begin
      x_a_ff   <= req_stick_x;
      y_a_ff   <= req_stick_y;
      dz_a_ff  <= dz_wide[F-1:0];
      pad_a_ff <= pad_ff;
   end

   // stage b: magnitudes and per-axis compares
   bstage_type b_in, b_ff;
   logic [W-1:0] abs_x, abs_y;

   always_comb begin
      abs_x     = x_a_ff[W-1] ? W'(~x_a_ff + 1'b1) : x_a_ff;
      abs_y     = y_a_ff[W-1] ? W'(~y_a_ff + 1'b1) : y_a_ff;
      b_in.ax   = abs_x;
      b_in.ay   = abs_y;
      b_in.negx = x_a_ff[W-1];
      b_in.negy = y_a_ff[W-1];
      b_in.ltx  = abs_x < {1'b0, dz_a_ff};
      b_in.lty  = abs_y < {1'b0, dz_a_ff};
      b_in.onex = abs_x[F];
      b_in.oney = abs_y[F];
      b_in.dz   = dz_a_ff;
      b_in.pad  = pad_a_ff;
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
   end

   // delay line carrying stage b fields
   bstage_type bl_ff [BL_LEN];
   always_ff @(posedge clock) begin
      bl_ff[0] <= b_ff;
      for (int i = 1; i < BL_LEN; i++) begin
         bl_ff[i] <= bl_ff[i-1];
      end
   end

   // axial dividers fed from stage b
   logic [F:0]   den_b;
   logic [F:0]   ahi_x, ahi_y;
   logic [F-1:0] aq_x, aq_y;

   assign den_b = ONE - {1'b0, b_ff.dz};
   assign ahi_x = (b_ff.ltx || b_ff.onex) ? '0 : b_ff.ax - {1'b0, b_ff.dz};
   assign ahi_y = (b_ff.lty || b_ff.oney) ? '0 : b_ff.ay - {1'b0, b_ff.dz};

   gsd_div #(.DW(F + 1), .QB(F)) u_div_axial_x (
      .clock   (clock),
      .in_hi   (ahi_x),
      .in_lo   ('0),
      .in_den  (den_b),
      .out_quo (aq_x)
   );

   gsd_div #(.DW(F + 1), .QB(F)) u_div_axial_y (
      .clock   (clock),
      .in_hi   (ahi_y),
      .in_lo   ('0),
      .in_den  (den_b),
      .out_quo (aq_y)
   );

   // axial results, then delay to the final stage
   bstage_type bq;
   axial_type  ax_res;
   axial_type  axl_ff [AX_LEN];

   assign bq = bl_ff[F-1];

   always_comb begin
      ax_res.ax = bq.ltx ? '0 : pack_mag(bq.negx, bq.onex ? ONE : {1'b0, aq_x});
      ax_res.ay = bq.lty ? '0 : pack_mag(bq.negy, bq.oney ? ONE : {1'b0, aq_y});
   end

   always_ff @(posedge clock) begin
      axl_ff[0] <= ax_res;
      for (int i = 1; i < AX_LEN; i++) begin
         axl_ff[i] <= axl_ff[i-1];
      end
   end

   // squares and sum of squares
   logic [2*F+1:0] sqx_ff, sqy_ff, sum_ff;
   logic [2*F+1:0] sqx_in, sqy_in;

   assign sqx_in = b_ff.ax * b_ff.ax;
   assign sqy_in = b_ff.ay * b_ff.ay;

   always_ff @(posedge clock) begin
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      sum_ff <= sqx_ff + sqy_ff;
   end

   // magnitude
   logic [F:0] mag;

   gsd_isqrt #(.F(F)) u_isqrt (
      .clock    (clock),
      .in_num   (sum_ff),
      .out_root (mag)
   );

   // deadzone test and scale divider
   bstage_type bm;
   mstage_type m_in;
   mstage_type km_ff [KM_LEN];
   logic [F:0]   den_m;
   logic [F:0]   shi;
   logic [F-1:0] s_quo;

   assign bm = bl_ff[F+2];

   always_comb begin
      m_in.m     = mag;
      m_in.in_dz = mag < {1'b0, bm.dz};
      m_in.rz    = (mag < {1'b0, bm.dz}) || (mag == '0);
      m_in.s_one = mag[F];
      den_m      = ONE - {1'b0, bm.dz};
      shi        = (m_in.rz || m_in.s_one) ? '0 : mag - {1'b0, bm.dz};
   end

   always_ff @(posedge clock) begin
      km_ff[0] <= m_in;
      for (int i = 1; i < KM_LEN; i++) begin
         km_ff[i] <= km_ff[i-1];
      end
   end

   gsd_div #(.DW(F + 1), .QB(F)) u_div_scale (
      .clock   (clock),
      .in_hi   (shi),
      .in_lo   ('0),
      .in_den  (den_m),
      .out_quo (s_quo)
   );

   // scale each component magnitude
   bstage_type bs;
   logic [F:0]     s_fin;
   logic [2*F+1:0] prodx, prody;
   logic [2*F:0]   px_ff, py_ff;

   assign bs    = bl_ff[2*F+2];
   assign s_fin = km_ff[F-1].s_one ? ONE : {1'b0, s_quo};
   assign prodx = bs.ax * s_fin;
   assign prody = bs.ay * s_fin;

   always_ff @(posedge clock) begin
      px_ff <= prodx[2*F:0];
      py_ff <= prody[2*F:0];
   end

   // divide scaled components by the magnitude
   logic [F:0] rq_x, rq_y;

   gsd_div #(.DW(F + 1), .QB(F + 1)) u_div_radial_x (
      .clock   (clock),
      .in_hi   ({1'b0, px_ff[2*F:F+1]}),
      .in_lo   (px_ff[F:0]),
      .in_den  (km_ff[F].m),
      .out_quo (rq_x)
   );

   gsd_div #(.DW(F + 1), .QB(F + 1)) u_div_radial_y (
      .clock   (clock),
      .in_hi   ({1'b0, py_ff[2*F:F+1]}),
      .in_lo   (py_ff[F:0]),
      .in_den  (km_ff[F].m),
      .out_quo (rq_y)
   );

   // final assembly
   bstage_type bf;
   mstage_type mf;
   axial_type  af;
   result_type res;
   logic       pipe_valid;

   assign bf         = bl_ff[3*F+4];
   assign mf         = km_ff[2*F+1];
   assign af         = axl_ff[2*F+4];
   assign pipe_valid = v_ff[V_LEN-1];

   always_comb begin
      res = '0;
      if (bf.pad) begin
         res.rx   = mf.rz ? '0 : pack_mag(bf.negx, rq_x);
         res.ry   = mf.rz ? '0 : pack_mag(bf.negy, rq_y);
         res.ax   = af.ax;
         res.ay   = af.ay;
         res.indz = mf.in_dz;
      end
   end

   // output queue and credit count
   result_type    mem [FIFO_DEPTH];
   logic [AW:0]   wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          rsp_valid_ff;
   result_type    out_ff;
   logic          q_empty;
   logic          load_out;
   logic          rsp_fire;

   assign q_empty   = wp_ff == rp_ff;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign load_out  = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = cnt_ff >= FULL;

   always_ff @(posedge clock) begin
      if (pipe_valid) begin
         mem[wp_ff[AW-1:0]] <= res;
      end
      if (load_out) begin
         out_ff <= mem[rp_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pipe_valid) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (load_out) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + (AW+1)'(req_fire) - (AW+1)'(rsp_fire);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_radial_x    = out_ff.rx;
   assign rsp_radial_y    = out_ff.ry;
   assign rsp_axial_x     = out_ff.ax;
   assign rsp_axial_y     = out_ff.ay;
   assign rsp_in_deadzone = out_ff.indz;

   // credit count never passes the queue size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL)
      else $error("credit count above queue depth");

   // a result leaving the pipeline always finds room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pipe_valid |-> (AW+1)'(wp_ff - rp_ff) < FULL)
      else $error("output queue overflow");

   // nothing in flight means nothing shown
   a_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !rsp_valid_ff)
      else $error("result shown with no sample in flight");

   // inside the deadzone the radial vector is zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_deadzone) |-> (rsp_radial_x == '0 && rsp_radial_y == '0))
      else $error("radial output nonzero inside deadzone");

endmodule

// ----- verif/gamepad_stick_deadzone_tb.sv -----
// self-checking testbench for the stick deadzone block: driver, monitor and result predictor
module gamepad_stick_deadzone_tb;

   localparam int SB = 16;
   localparam int FRAC = SB - 1;
   localparam longint UNIT = longint'(1) << FRAC;
   localparam logic [gsd_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd2;
   localparam int DRAIN_CYCLES = 3 * SB + 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PER_PHASE = 156;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic signed [SB-1:0] x;
      logic signed [SB-1:0] y;
   } stick_sample_type;

   typedef struct {
      logic signed [SB-1:0] radial_x;
      logic signed [SB-1:0] radial_y;
      logic signed [SB-1:0] axial_x;
      logic signed [SB-1:0] axial_y;
      logic                 in_deadzone;
   } conditioned_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [SB-1:0] req_stick_x, req_stick_y;
   logic rsp_valid, rsp_stall;
   logic signed [SB-1:0] rsp_radial_x, rsp_radial_y, rsp_axial_x, rsp_axial_y;
   logic rsp_in_deadzone;
   logic csr_write;
   logic [gsd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [gsd_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   gamepad_stick_deadzone #(.SAMPLE_BITS(SB)) dut (.*);

   // predictor copy of the registers
   logic [14:0] dz_reg;
   logic        pad_on;

   stick_sample_type sample_q[$];
   conditioned_type  conditioned_q[$];
   int  send_idle_pct, recv_idle_pct;
   int  mismatches, results_seen, samples_sent, cycles;
   bit  sample_taken;

   // floor of the square root, bit by bit
   function automatic longint root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   // sign and saturate a magnitude into the sample range
   function automatic logic signed [SB-1:0] signed_sat(bit neg, longint mag);
      if (neg) return SB'(-((mag > UNIT) ? UNIT : mag));
      return SB'((mag > UNIT - 1) ? UNIT - 1 : mag);
   endfunction

   function automatic logic signed [SB-1:0] axis_condition(longint v, longint dz);
      longint a;
      a = v < 0 ? -v : v;
      if (a < dz) return '0;
      return signed_sat(v < 0, ((a - dz) * UNIT) / (UNIT - dz));
   endfunction

   function automatic conditioned_type condition_stick(stick_sample_type s);
      conditioned_type r;
      longint x, y, ax, ay, dz, m, sc;
      r = '{default: '0};
      if (!pad_on) return r;
      x = s.x;
      y = s.y;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      dz = (longint'(dz_reg) * UNIT) >>> 15;
      m = root_floor(ax * ax + ay * ay);
      r.in_deadzone = m < dz;
      if (m >= dz && m > 0) begin
         sc = ((m - dz) * UNIT) / (UNIT - dz);
         if (sc > UNIT) sc = UNIT;
         r.radial_x = signed_sat(x < 0, (ax * sc) / m);
         r.radial_y = signed_sat(y < 0, (ay * sc) / m);
      end
      r.axial_x = axis_condition(x, dz);
      r.axial_y = axis_condition(y, dz);
      return r;
   endfunction

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // input transfer: record the expectation
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         conditioned_q.push_back(condition_stick('{x: req_stick_x, y: req_stick_y}));
         samples_sent++;
         sample_taken = 1;
      end
   end

   // driver: new sample after a transfer or while idle
   always @(negedge clock) begin
      stick_sample_type s;
      if (!reset && (!req_valid || sample_taken)) begin
         if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            s = sample_q.pop_front();
            req_valid <= 1'b1;
            req_stick_x <= s.x;
            req_stick_y <= s.y;
         end else begin
            req_valid <= 1'b0;
         end
      end
      sample_taken = 0;
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      conditioned_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (conditioned_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) $display("result with no sample pending");
         end else begin
            e = conditioned_q.pop_front();
            if (rsp_radial_x !== e.radial_x || rsp_radial_y !== e.radial_y ||
                rsp_axial_x !== e.axial_x || rsp_axial_y !== e.axial_y ||
                rsp_in_deadzone !== e.in_deadzone) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch: exp r=(%0d,%0d) a=(%0d,%0d) dz=%b",
                     e.radial_x, e.radial_y, e.axial_x, e.axial_y, e.in_deadzone,
                     " got r=(%0d,%0d) a=(%0d,%0d) dz=%b",
                     rsp_radial_x, rsp_radial_y, rsp_axial_x, rsp_axial_y, rsp_in_deadzone);
            end
         end
      end
   end

   task automatic add_sample(int x, int y);
      sample_q.push_back('{x: SB'(x), y: SB'(y)});
   endtask

   // wait until every sent sample has its result, then let the pipe settle
   task automatic wait_idle();
      while (sample_q.size() != 0 || req_valid || conditioned_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic reg_write(logic [gsd_pkg::CSR_INDEX_BITS-1:0] idx, int value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= gsd_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == gsd_pkg::CSR_DEADZONE) dz_reg = 15'(value);
      else if (idx == gsd_pkg::CSR_PAD_PRESENT) pad_on = value[0];
   endtask

   // random samples: mostly uniform, some near the deadzone edge, some extreme and some near zero
   task automatic random_samples(int n);
      int d, x, y, k;
      for (int i = 0; i < n; i++) begin
         d = dz_reg;
         k = $urandom_range(9);
         if (k < 4) begin
            x = $urandom_range(65535) - 32768;
            y = $urandom_range(65535) - 32768;
         end else if (k < 7) begin
            x = int'($urandom_range(2 * d + 64)) - d - 32;
            y = int'($urandom_range(2 * d + 64)) - d - 32;
         end else if (k < 9) begin
            x = $urandom_range(1) ? 32767 - $urandom_range(300) : -32768 + $urandom_range(300);
            y = $urandom_range(65535) - 32768;
            if ($urandom_range(1)) begin
               d = x;
               x = y;
               y = d;
            end
         end else begin
            x = $urandom_range(15) - 8;
            y = $urandom_range(15) - 8;
         end
         add_sample(x, y);
      end
   endtask

   task automatic directed_samples();
      int d;
      d = dz_reg;
      add_sample(0, 0);
      add_sample(32767, 32767);
      add_sample(-32768, -32768);
      add_sample(-32768, 32767);
      add_sample(32767, 0);
      add_sample(-32768, 0);
      add_sample(0, -32768);
      add_sample(1, 0);
      add_sample(-1, -1);
      add_sample(d, 0);
      add_sample(d - 1, 0);
      add_sample(0, -d);
      add_sample(-(d + 1), d + 1);
      add_sample(23170, 23170);
      add_sample(-23171, 23170);
   endtask

   // one configuration phase with the idling style picked by the phase number
   task automatic run_phase(int phase);
      case (phase % 3)
         0: begin
            send_idle_pct = 15;
            recv_idle_pct = 48;
         end
         1: begin
            send_idle_pct = 48;
            recv_idle_pct = 15;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      directed_samples();
      random_samples(RAND_PER_PHASE / 2);
      // sender holds off until the block has drained
      wait_idle();
      random_samples(RAND_PER_PHASE / 2);
      wait_idle();
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_stick_x = '0;
      req_stick_y = '0;
      rsp_stall = 0;
      csr_write = 0;
      csr_index = gsd_pkg::CSR_DEADZONE;
      csr_wdata = '0;
      dz_reg = gsd_pkg::DZ_RESET;
      pad_on = 1;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      mismatches = 0;
      results_seen = 0;
      samples_sent = 0;
      cycles = 0;
      sample_taken = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset values first, then a sweep of register settings
      run_phase(0);
      reg_write(gsd_pkg::CSR_DEADZONE, 0);
      run_phase(1);
      reg_write(gsd_pkg::CSR_DEADZONE, 32112);
      run_phase(2);
      reg_write(gsd_pkg::CSR_DEADZONE, 32767);
      reg_write(CSR_SPARE_INDEX, 5);
      run_phase(3);
      reg_write(gsd_pkg::CSR_PAD_PRESENT, 0);
      run_phase(4);
      reg_write(gsd_pkg::CSR_PAD_PRESENT, 1);
      reg_write(gsd_pkg::CSR_DEADZONE, 1);
      reg_write(CSR_SPARE_INDEX + 2'd1, 0);
      run_phase(5);
      reg_write(gsd_pkg::CSR_DEADZONE, 16384);
      run_phase(6);

      $display("covered %0d samples, %0d results, deadzone from 0 to full scale, pad absent",
         samples_sent, results_seen);
      $display("idling on each side in turn and none; unmapped register writes ignored");
      if (mismatches == 0 && conditioned_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, conditioned_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
